FILE: design/magnetometer_minmax_calibrate_normalize_macros.svh
// Assertion helpers for the checker file.
`ifndef MAGNETOMETER_MINMAX_CALIBRATE_NORMALIZE_MACROS_SVH
`define MAGNETOMETER_MINMAX_CALIBRATE_NORMALIZE_MACROS_SVH

// Clocked assertion, off while reset is held
`define MMCN_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, checked during reset too
`define MMCN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/mmcn_pkg.sv
package mmcn_pkg;

    // Fixed field widths
    localparam int SAMPLE_BITS  = 16;
    localparam int OUT_BITS     = 16;
    localparam int ELAPSED_BITS = 16;
    localparam int CAL_BITS     = 31;
    localparam int COUNT_BITS   = 32;

    // Calibration countdown start value after reset
    localparam logic [CAL_BITS-1:0] CAL_TIME_RESET = 31'd30000;

    // Operation codes
    localparam logic OP_CALIBRATE = 1'b0;
    localparam logic OP_FILTER    = 1'b1;

    typedef struct packed {
        logic                          operation;
        logic signed [SAMPLE_BITS-1:0] sample_x;
        logic signed [SAMPLE_BITS-1:0] sample_y;
        logic signed [SAMPLE_BITS-1:0] sample_z;
        logic        [ELAPSED_BITS-1:0] elapsed;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] out_x;
        logic signed [OUT_BITS-1:0] out_y;
        logic signed [OUT_BITS-1:0] out_z;
        logic                       still_calibrating;
        logic                       in_progress;
        logic                       done_res;
    } t_out_item;

endpackage

FILE: design/magnetometer_minmax_calibrate_normalize.sv
// A filter item runs the one restoring divider for each of the three axes in turn, skipping the
// division for an axis with zero span; a calibrate item needs no division. Output stalls hold
// the block in its emit state. The block takes one item at a time: no new item is accepted
// until the result of the last one is in the output register.
// Reset (synchronous, active low) sets min to the most positive sample, max to the most
// negative sample, calibration_time and countdown to 30000, and empties the output register.
module magnetometer_minmax_calibrate_normalize #(
    parameter int FRAC_BITS = 14
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  mmcn_pkg::t_in_item                i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output mmcn_pkg::t_out_item               o_out_item,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mmcn_pkg::CAL_BITS-1:0]     i_cfg_data
);

    localparam int SB       = mmcn_pkg::SAMPLE_BITS;
    localparam int OB       = mmcn_pkg::OUT_BITS;
    localparam int CB       = mmcn_pkg::COUNT_BITS;
    localparam int QB       = SB + FRAC_BITS + 2;
    localparam int VB       = QB + 2;
    localparam int CNT_BITS = $clog2(QB);

    localparam logic signed [VB-1:0] V_ONE    = VB'(1) << FRAC_BITS;
    localparam logic signed [VB-1:0] V_BIG    = VB'(1) << QB;
    localparam logic signed [VB-1:0] V_OUT_HI = VB'((2**(OB-1)) - 1);
    localparam logic signed [VB-1:0] V_OUT_LO = ~V_OUT_HI;

    localparam logic signed [SB-1:0] SAMPLE_HI = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SAMPLE_LO = {1'b1, {(SB-1){1'b0}}};

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CAL  = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_POST = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0]                       r_state;
    mmcn_pkg::t_in_item               r_item;
    logic signed [SB-1:0]             r_min [3];
    logic signed [SB-1:0]             r_max [3];
    logic [mmcn_pkg::CAL_BITS-1:0]    r_cal_time;
    logic signed [CB-1:0]             r_countdown;
    logic [1:0]                       r_axis;
    logic [CNT_BITS-1:0]              r_cnt;
    logic [QB-1:0]                    r_work;
    logic [SB-1:0]                    r_rem;
    logic [SB-1:0]                    r_den;
    logic                             r_neg;
    logic                             r_zero_span;
    logic                             r_zero_diff;
    logic signed [OB-1:0]             r_res [3];
    logic                             r_out_valid;
    mmcn_pkg::t_out_item              r_out_item;

    logic signed [SB-1:0]             w_s;
    logic signed [SB:0]               w_diff;
    logic signed [SB:0]               w_span;
    logic [SB:0]                      w_n;
    logic [SB:0]                      w_d;
    logic [SB:0]                      w_trial;
    logic [SB+1:0]                    w_sub;
    logic                             w_ge;
    logic [QB:0]                      w_round;
    logic signed [VB-1:0]             w_mag;
    logic signed [VB-1:0]             w_val;
    logic signed [VB-1:0]             w_axis_val;
    logic signed [OB-1:0]             w_sat;
    logic signed [CB:0]               w_cd_next;
    logic                             w_still;
    logic                             w_in_prog;
    logic                             w_out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // Select the operands of the current axis and form diff and span
    always_comb begin
        case (r_axis)
            AXIS_X:  w_s = r_item.sample_x;
            AXIS_Y:  w_s = r_item.sample_y;
            default: w_s = r_item.sample_z;
        endcase
        w_diff = {w_s[SB-1], w_s} - {r_min[r_axis][SB-1], r_min[r_axis]};
        w_span = {r_max[r_axis][SB-1], r_max[r_axis]} - {r_min[r_axis][SB-1], r_min[r_axis]};
        w_n    = w_diff[SB] ? -w_diff : w_diff;
        w_d    = w_span[SB] ? -w_span : w_span;
    end

    // One restoring division step: shift in a dividend bit, subtract if it fits
    always_comb begin
        w_trial = {r_rem, r_work[QB-1]};
        w_sub   = {1'b0, w_trial} - {2'b00, r_den};
        w_ge    = !w_sub[SB+1];
    end

    // Round the quotient, apply sign and offset, negate x, saturate
    always_comb begin
        w_round = {1'b0, r_work} + (QB+1)'(1);
        w_mag   = VB'(w_round[QB:1]);
        if (r_zero_span) begin
            if (r_zero_diff) begin
                w_val = -V_ONE;
            end else if (r_neg) begin
                w_val = -V_BIG;
            end else begin
                w_val = V_BIG;
            end
        end else begin
            w_val = (r_neg ? -w_mag : w_mag) - V_ONE;
        end
        w_axis_val = (r_axis == AXIS_X) ? -w_val : w_val;
        if (w_axis_val > V_OUT_HI) begin
            w_sat = V_OUT_HI[OB-1:0];
        end else if (w_axis_val < V_OUT_LO) begin
            w_sat = V_OUT_LO[OB-1:0];
        end else begin
            w_sat = w_axis_val[OB-1:0];
        end
    end

    // Countdown after a calibrate item, and status flags of the stored countdown
    always_comb begin
        w_cd_next = {r_countdown[CB-1], r_countdown} - (CB+1)'(r_item.elapsed);
        w_still   = !r_countdown[CB-1] && (r_countdown != '0);
        w_in_prog = w_still && (r_countdown[CB-2:0] < r_cal_time);
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cal_time  <= mmcn_pkg::CAL_TIME_RESET;
            r_countdown <= CB'(mmcn_pkg::CAL_TIME_RESET);
            r_axis      <= AXIS_X;
            r_cnt       <= '0;
            for (int i = 0; i < 3; i++) begin
                r_min[i] <= SAMPLE_HI;
                r_max[i] <= SAMPLE_LO;
            end
        end else begin
            // Drop a delivered item; the emit state refills the register itself
            if (r_out_valid && i_out_ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        r_cal_time  <= i_cfg_data;
                        r_countdown <= {1'b0, i_cfg_data};
                    end
                    if (i_in_valid) begin
                        r_item <= i_in_item;
                        r_axis <= AXIS_X;
                        r_state <= (i_in_item.operation == mmcn_pkg::OP_CALIBRATE)
                                   ? S_CAL : S_LOAD;
                    end
                end
                S_CAL: begin
                    // Widen min and max, advance the countdown with saturation
                    if (r_item.sample_x < r_min[0]) r_min[0] <= r_item.sample_x;
                    if (r_item.sample_y < r_min[1]) r_min[1] <= r_item.sample_y;
                    if (r_item.sample_z < r_min[2]) r_min[2] <= r_item.sample_z;
                    if (r_item.sample_x > r_max[0]) r_max[0] <= r_item.sample_x;
                    if (r_item.sample_y > r_max[1]) r_max[1] <= r_item.sample_y;
                    if (r_item.sample_z > r_max[2]) r_max[2] <= r_item.sample_z;
                    if (w_cd_next[CB] != w_cd_next[CB-1]) begin
                        r_countdown <= {1'b1, {(CB-1){1'b0}}};
                    end else begin
                        r_countdown <= w_cd_next[CB-1:0];
                    end
                    for (int i = 0; i < 3; i++) begin
                        r_res[i] <= '0;
                    end
                    r_state <= S_EMIT;
                end
                S_LOAD: begin
                    r_zero_span <= (w_span == '0);
                    r_zero_diff <= (w_diff == '0);
                    r_rem       <= '0;
                    r_den       <= w_d[SB-1:0];
                    r_work      <= {w_n[SB-1:0], {(FRAC_BITS+2){1'b0}}};
                    r_cnt       <= CNT_BITS'(QB - 1);
                    if (w_span == '0) begin
                        r_neg   <= w_diff[SB];
                        r_state <= S_POST;
                    end else begin
                        r_neg   <= w_diff[SB] ^ w_span[SB];
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= w_ge ? w_sub[SB-1:0] : w_trial[SB-1:0];
                    r_work <= {r_work[QB-2:0], w_ge};
                    if (r_cnt == '0) begin
                        r_state <= S_POST;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_POST: begin
                    r_res[r_axis] <= w_sat;
                    if (r_axis == AXIS_Z) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_axis  <= r_axis + 1'b1;
                        r_state <= S_LOAD;
                    end
                end
                S_EMIT: begin
                    // Hold until the output register is free
                    if (w_out_free) begin
                        r_out_valid                  <= 1'b1;
                        r_out_item.out_x             <= r_res[2];
                        r_out_item.out_y             <= r_res[0];
                        r_out_item.out_z             <= r_res[1];
                        r_out_item.still_calibrating <= w_still;
                        r_out_item.in_progress       <= w_in_prog;
                        r_out_item.done_res          <= !w_still;
                        r_state                      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: design/mmcn_checker.sv
`include "magnetometer_minmax_calibrate_normalize_macros.svh"

module mmcn_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input mmcn_pkg::t_out_item           o_out_item
);

    // A stalled result item holds
    `MMCN_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)), "result item changed while stalled")

    // One item at a time: no accept right after an accept
    `MMCN_ASSERT(a_one_at_a_time, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready, "input accepted while an item is at work")

    // Calibrating and finished are exclusive and cover every result
    `MMCN_ASSERT(a_status_excl, i_clk, i_rst_n, o_out_valid |-> (o_out_item.still_calibrating ^ o_out_item.done_res), "status flags inconsistent")

    // In progress implies still calibrating
    `MMCN_ASSERT(a_progress, i_clk, i_rst_n, (o_out_valid && o_out_item.in_progress) |-> o_out_item.still_calibrating, "in progress without calibrating")

    // Reset empties the output register
    `MMCN_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind magnetometer_minmax_calibrate_normalize mmcn_checker u_mmcn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

FILE: sim/magnetometer_minmax_calibrate_normalize_tb.sv
`timescale 1ns / 1ps

module magnetometer_minmax_calibrate_normalize_tb;

    localparam int     FRAC_BITS   = 14;
    localparam longint COUNT_FLOOR = -64'sd2147483648;
    localparam longint OUT_HI      = 32767;
    localparam longint OUT_LO      = -32768;
    localparam longint WIDE        = 64'sd1 <<< 40;
    localparam int     LONG_HOLD   = 400;

    // Track calibration state and hold the results still owed by the block
    class magcal_tracker;
        logic signed [mmcn_pkg::SAMPLE_BITS-1:0] axis_lo[3];
        logic signed [mmcn_pkg::SAMPLE_BITS-1:0] axis_hi[3];
        logic        [mmcn_pkg::CAL_BITS-1:0]    cal_time;
        longint                                  countdown;
        mmcn_pkg::t_out_item                     expected_outputs[$];
        int                                      errors;

        function new();
            for (int a = 0; a < 3; a++) begin
                axis_lo[a] = 16'sh7FFF;
                axis_hi[a] = 16'sh8000;
            end
            cal_time  = mmcn_pkg::CAL_TIME_RESET;
            countdown = longint'(mmcn_pkg::CAL_TIME_RESET);
            errors    = 0;
        endfunction

        function void load_cal_time(logic [mmcn_pkg::CAL_BITS-1:0] value);
            cal_time  = value;
            countdown = longint'(value);
        endfunction

        // Map one axis to 2*(s-lo)/(hi-lo)-1, unsaturated, rounded half away from zero
        function longint scaled_axis(logic signed [mmcn_pkg::SAMPLE_BITS-1:0] s,
                                     logic signed [mmcn_pkg::SAMPLE_BITS-1:0] lo,
                                     logic signed [mmcn_pkg::SAMPLE_BITS-1:0] hi);
            longint diff, span, num, den, mag, unit;
            bit     negative;
            diff = longint'(s) - longint'(lo);
            span = longint'(hi) - longint'(lo);
            unit = 64'sd1 <<< FRAC_BITS;
            if (span == 0) begin
                if (diff > 0) return WIDE;
                if (diff < 0) return -WIDE;
                return -unit;
            end
            negative = (diff < 0) != (span < 0);
            num = (diff < 0) ? -diff : diff;
            den = (span < 0) ? -span : span;
            mag = (((num <<< (FRAC_BITS + 2)) / den) + 1) >>> 1;
            return (negative ? -mag : mag) - unit;
        endfunction

        function logic signed [mmcn_pkg::OUT_BITS-1:0] clip_q14(longint v);
            if (v > OUT_HI) v = OUT_HI;
            if (v < OUT_LO) v = OUT_LO;
            return v[mmcn_pkg::OUT_BITS-1:0];
        endfunction

        // Apply one accepted item and queue the result it owes
        function void absorb_sample(mmcn_pkg::t_in_item it);
            logic signed [mmcn_pkg::SAMPLE_BITS-1:0] s[3];
            mmcn_pkg::t_out_item                     want;
            s[0] = it.sample_x;
            s[1] = it.sample_y;
            s[2] = it.sample_z;
            if (it.operation == mmcn_pkg::OP_CALIBRATE) begin
                for (int a = 0; a < 3; a++) begin
                    if (s[a] > axis_hi[a]) axis_hi[a] = s[a];
                    if (s[a] < axis_lo[a]) axis_lo[a] = s[a];
                end
                countdown = countdown - longint'(it.elapsed);
                if (countdown < COUNT_FLOOR) countdown = COUNT_FLOOR;
                want.out_x = '0;
                want.out_y = '0;
                want.out_z = '0;
            end else begin
                // Reorder axes to (z, -x, y)
                want.out_x = clip_q14(scaled_axis(s[2], axis_lo[2], axis_hi[2]));
                want.out_y = clip_q14(-scaled_axis(s[0], axis_lo[0], axis_hi[0]));
                want.out_z = clip_q14(scaled_axis(s[1], axis_lo[1], axis_hi[1]));
            end
            want.still_calibrating = countdown > 0;
            want.in_progress       = (countdown > 0) && (countdown < longint'(cal_time));
            want.done_res          = countdown <= 0;
            expected_outputs.push_back(want);
        endfunction

        function void check_field(string name, logic signed [mmcn_pkg::OUT_BITS-1:0] want,
                                  logic signed [mmcn_pkg::OUT_BITS-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(mmcn_pkg::t_out_item got);
            mmcn_pkg::t_out_item want;
            if (expected_outputs.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = expected_outputs.pop_front();
            check_field("out_x", want.out_x, got.out_x);
            check_field("out_y", want.out_y, got.out_y);
            check_field("out_z", want.out_z, got.out_z);
            check_field("still_calibrating", want.still_calibrating, got.still_calibrating);
            check_field("in_progress", want.in_progress, got.in_progress);
            check_field("done_res", want.done_res, got.done_res);
        endfunction

        function int outstanding();
            return expected_outputs.size();
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_ready;
    mmcn_pkg::t_in_item              i_in_item;
    logic                            o_out_valid;
    logic                            i_out_ready;
    mmcn_pkg::t_out_item             o_out_item;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [mmcn_pkg::CAL_BITS-1:0]   i_cfg_data;

    magcal_tracker tracker = new();
    int            burst_left = 0;
    bit            no_gaps = 1'b0;
    bit            long_hold_req = 1'b0;

    magnetometer_minmax_calibrate_normalize dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Give up on a hung run
    initial begin
        #30ms;
        $display("magnetometer_minmax_calibrate_normalize regression: fail");
        $finish;
    end

    // Accept results and stall on a changing pattern, with one long hold-off on request
    initial begin : result_side
        int mode, mode_left, hold_left;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) tracker.check_result(o_out_item);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 150);
                end
                mode_left--;
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    2: i_out_ready <= ($urandom_range(0, 3) == 0);
                    default: i_out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    function automatic mmcn_pkg::t_in_item item_of(logic op, int x, int y, int z, int el);
        mmcn_pkg::t_in_item it;
        it.operation = op;
        it.sample_x  = x[mmcn_pkg::SAMPLE_BITS-1:0];
        it.sample_y  = y[mmcn_pkg::SAMPLE_BITS-1:0];
        it.sample_z  = z[mmcn_pkg::SAMPLE_BITS-1:0];
        it.elapsed   = el[mmcn_pkg::ELAPSED_BITS-1:0];
        return it;
    endfunction

    // Pick a reading within +/- spread of zero, clipped to the sample range
    function automatic int pick_axis(int spread);
        int v;
        v = int'($urandom_range(0, 2 * spread)) - spread;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    function automatic int pick_elapsed();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 65535;
            2: return $urandom_range(0, 255);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic mmcn_pkg::t_in_item make_item(logic op, int spread);
        return item_of(op, pick_axis(spread), pick_axis(spread), pick_axis(spread),
                       pick_elapsed());
    endfunction

    // Offer one item in bursts separated by random gaps; hold until accepted
    task automatic send_item(input mmcn_pkg::t_in_item it);
        int gap;
        if (burst_left == 0 && !no_gaps) begin
            gap = $urandom_range(0, 14);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        if (burst_left > 0) burst_left--;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tracker.absorb_sample(it);
    endtask

    // Stop offering and wait for every owed result
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic write_cal_time(input logic [mmcn_pkg::CAL_BITS-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.load_cal_time(value);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly calibrate runs followed by filter runs, with some stray items mixed in
    task automatic run_phase(input logic [mmcn_pkg::CAL_BITS-1:0] cal_value, input int spread,
                             input int n_items);
        int                 sent, run_cal, run_filt;
        logic               op;
        mmcn_pkg::t_in_item it;
        drain_results();
        write_cal_time(cal_value);
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 6) == 0) begin
                op = 1'($urandom_range(0, 1));
                it = make_item(op, (op == mmcn_pkg::OP_FILTER) ? 32768 : 2 * spread);
                send_item(it);
                sent++;
            end else begin
                run_cal  = $urandom_range(1, 6);
                run_filt = $urandom_range(1, 8);
                repeat (run_cal) send_item(make_item(mmcn_pkg::OP_CALIBRATE, spread));
                repeat (run_filt) send_item(make_item(mmcn_pkg::OP_FILTER, spread + spread / 2));
                sent += run_cal + run_filt;
            end
        end
    endtask

    initial begin : stimulus
        mmcn_pkg::t_in_item it;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Filter before any calibration: max below min
        send_item(item_of(mmcn_pkg::OP_FILTER, 0, 0, 0, 0));
        send_item(item_of(mmcn_pkg::OP_FILTER, 32767, -32768, -1, 65535));
        send_item(item_of(mmcn_pkg::OP_FILTER, -32768, 32767, 1, 0));
        // Single calibrate point: zero span on every axis
        send_item(item_of(mmcn_pkg::OP_CALIBRATE, 0, 0, 0, 0));
        send_item(item_of(mmcn_pkg::OP_FILTER, 1, -1, 0, 0));
        send_item(item_of(mmcn_pkg::OP_FILTER, -1, 1, 0, 0));
        // Widen moderately while the countdown runs
        send_item(item_of(mmcn_pkg::OP_CALIBRATE, 100, -200, 300, 1000));
        send_item(item_of(mmcn_pkg::OP_CALIBRATE, -100, 200, -300, 1));
        send_item(item_of(mmcn_pkg::OP_FILTER, 100, -200, 300, 0));
        send_item(item_of(mmcn_pkg::OP_FILTER, 0, 0, 0, 0));
        send_item(item_of(mmcn_pkg::OP_FILTER, 33, 7, -150, 0));
        send_item(item_of(mmcn_pkg::OP_FILTER, 32767, -32768, 32767, 0));
        send_item(item_of(mmcn_pkg::OP_FILTER, -32768, 32767, -32768, 0));
        // Finish the countdown, then keep calibrating after done
        send_item(item_of(mmcn_pkg::OP_CALIBRATE, 600, -700, 800, 65535));
        send_item(item_of(mmcn_pkg::OP_CALIBRATE, -900, 900, -50, 65535));
        send_item(item_of(mmcn_pkg::OP_FILTER, 0, -1, 32767, 0));
        send_item(item_of(mmcn_pkg::OP_FILTER, -32768, 32767, 12345, 0));

        // Random phases with growing spread and varied countdown start
        run_phase(31'd0, 400, 60);
        run_phase(31'd1, 2000, 60);
        long_hold_req = 1'b1;
        run_phase(31'd40000, 12000, 70);
        run_phase(31'($urandom), 32768, 65);
        run_phase(31'h7FFF_FFFF, 32768, 70);
        run_phase(31'd3000, 32768, 65);

        // Run the countdown negative with back-to-back calibrate items
        drain_results();
        write_cal_time(31'd0);
        no_gaps = 1'b1;
        repeat (20) begin
            it         = make_item(mmcn_pkg::OP_CALIBRATE, 32768);
            it.elapsed = 16'hFFFF;
            send_item(it);
        end
        no_gaps = 1'b0;
        repeat (12) send_item(make_item(mmcn_pkg::OP_FILTER, 32768));

        // Wait out the last results and any stray ones
        drain_results();
        repeat (150) @(posedge i_clk);
        if (tracker.errors == 0)
            $display("magnetometer_minmax_calibrate_normalize regression: pass");
        else
            $display("magnetometer_minmax_calibrate_normalize regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/mmcn_pkg.sv
design/magnetometer_minmax_calibrate_normalize.sv
design/mmcn_checker.sv
sim/magnetometer_minmax_calibrate_normalize_tb.sv
